/* rtl/hlr_pkg.sv */
`timescale 1ns / 1ps
// hlr_pkg: shared types and constants for the heat line rasterizer
// no dependencies; imported by hlr_seq, hlr_update and heat_line_rasterizer

package hlr_pkg;

  // fixed field widths of the block's ports
  localparam int COORD_W   = 6;
  localparam int GAIN_W    = 8;
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_COLOR  = 2'd2;

  // configuration reset values
  localparam logic [GAIN_W-1:0]  HEAT_GAIN_RST  = 8'd128;
  localparam logic [COLOR_W-1:0] COLD_COLOR_RST = 24'h000000;
  localparam logic [COLOR_W-1:0] HOT_COLOR_RST  = 24'hFF0000;

  // operation codes
  localparam logic OP_LINE = 1'b0;
  localparam logic OP_COOL = 1'b1;

  // 8-bit unit scale (255 = 1.0) and its rounding half
  localparam logic [GAIN_W-1:0] UNIT_SCALE = 8'd255;
  localparam logic [GAIN_W-1:0] UNIT_HALF  = 8'd127;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_LINE,
    ST_COOL
  } hlr_state_t;

  // one memory read issued by the sequencer, with the tag that follows it
  typedef struct packed {
    logic               valid;
    logic               cool;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [GAIN_W-1:0]  factor;
  } hlr_issue_t;

endpackage

/* rtl/hlr_ram.sv */
`timescale 1ns / 1ps
// hlr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module hlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hlr_cdiv.sv */
`timescale 1ns / 1ps
// hlr_cdiv: registered divide of an unsigned value by a constant
// reciprocal multiply with rounded-up multiplier, exact for every NUM_W-bit input whose quotient fits in Q_W bits

module hlr_cdiv #(
  parameter int NUM_W   = 16,
  parameter int DIVISOR = 255,
  parameter int Q_W     = 8
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  output logic [Q_W-1:0]   quo
);

  localparam int L  = $clog2(DIVISOR);
  localparam int S  = NUM_W + L;
  localparam int MW = NUM_W + 2;
  localparam int PW = NUM_W + MW;
  localparam logic [63:0] M_FULL =
    ((64'd1 << S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] MULT = M_FULL[MW-1:0];

  logic [PW-1:0]  prod;
  logic [Q_W-1:0] quo_r;

  assign prod = PW'(num) * PW'(MULT);

  always_ff @(posedge clk) begin
    quo_r <= prod[S +: Q_W];
  end

  assign quo = quo_r;

endmodule

/* rtl/hlr_seq.sv */
`timescale 1ns / 1ps
// hlr_seq: control sequencer - clearing pass, line walk and cooling sweep
// depends on hlr_pkg; issues one heat store read per cycle

module hlr_seq
  import hlr_pkg::*;
#(
  parameter int MAP_SIDE = 64,
  localparam int CW = $clog2(MAP_SIDE),
  localparam int DEPTH = MAP_SIDE * MAP_SIDE,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               pipe_busy,
  input  logic               in_operation,
  input  logic [COORD_W-1:0] in_x_start,
  input  logic [COORD_W-1:0] in_y_start,
  input  logic [COORD_W-1:0] in_x_end,
  input  logic [COORD_W-1:0] in_y_end,
  input  logic [GAIN_W-1:0]  in_cool_factor,
  output logic               busy,
  output hlr_issue_t         issue,
  output logic [AW-1:0]      rd_addr,
  output logic               clr_we,
  output logic [AW-1:0]      clr_addr
);

  localparam int EW = CW + 3;
  localparam logic [COORD_W:0] SIDE_EXT = (COORD_W + 1)'(MAP_SIDE);
  localparam logic [AW-1:0]    CNT_LAST = AW'(DEPTH - 1);

  hlr_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  logic [CW-1:0]     x0_r, y0_r, x1_r, y1_r;
  logic [GAIN_W-1:0] factor_r;
  logic [CW-1:0]     a_r, a_end_r, b_r, da_r, db_r;
  logic [EW-1:0]     err_r;
  logic              steep_r, step_neg_r;

  logic load_in, load_setup, line_adv;

  // setup arithmetic
  logic [CW-1:0] dx, dy, pa0, pb0, pa1, pb1, sa0, sa1, sb0, sb1, s_da, s_db;
  logic          steep, swap, s_step_neg;

  // walk arithmetic
  logic [EW-1:0] err_sub, err_add;
  logic [CW-1:0] px, py;
  logic          line_last;
  logic [AW-1:0] line_addr;

  function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W:0] v_ext;
    v_ext = {1'b0, v};
    if (v_ext >= SIDE_EXT) begin
      return CW'(MAP_SIDE - 1);
    end
    return v[CW-1:0];
  endfunction

  always_comb begin
    dx         = (x1_r > x0_r) ? x1_r - x0_r : x0_r - x1_r;
    dy         = (y1_r > y0_r) ? y1_r - y0_r : y0_r - y1_r;
    steep      = dy > dx;
    pa0        = steep ? y0_r : x0_r;
    pb0        = steep ? x0_r : y0_r;
    pa1        = steep ? y1_r : x1_r;
    pb1        = steep ? x1_r : y1_r;
    swap       = pa0 > pa1;
    sa0        = swap ? pa1 : pa0;
    sa1        = swap ? pa0 : pa1;
    sb0        = swap ? pb1 : pb0;
    sb1        = swap ? pb0 : pb1;
    s_da       = sa1 - sa0;
    s_db       = (sb1 > sb0) ? sb1 - sb0 : sb0 - sb1;
    s_step_neg = !(sb0 < sb1);
  end

  always_comb begin
    err_sub   = err_r - (EW'(db_r) << 1);
    err_add   = err_sub + (EW'(da_r) << 1);
    px        = steep_r ? b_r : a_r;
    py        = steep_r ? a_r : b_r;
    line_last = (a_r == a_end_r);
    line_addr = AW'(py) * AW'(MAP_SIDE) + AW'(px);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    busy       = 1'b1;
    issue      = '0;
    rd_addr    = line_addr;
    clr_we     = 1'b0;
    clr_addr   = cnt_r;
    load_in    = 1'b0;
    load_setup = 1'b0;
    line_adv   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        busy = pipe_busy;
        if (start && !pipe_busy) begin
          load_in   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = (in_operation == OP_COOL) ? ST_COOL : ST_SETUP;
        end
      end
      ST_SETUP: begin
        load_setup = 1'b1;
        state_nxt  = ST_LINE;
      end
      ST_LINE: begin
        issue.valid = 1'b1;
        issue.cool  = 1'b0;
        issue.last  = line_last;
        issue.x     = COORD_W'(px);
        issue.y     = COORD_W'(py);
        rd_addr     = line_addr;
        line_adv    = 1'b1;
        if (line_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_COOL: begin
        issue.valid  = 1'b1;
        issue.cool   = 1'b1;
        issue.factor = factor_r;
        rd_addr      = cnt_r;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      x0_r     <= clamp_coord(in_x_start);
      y0_r     <= clamp_coord(in_y_start);
      x1_r     <= clamp_coord(in_x_end);
      y1_r     <= clamp_coord(in_y_end);
      factor_r <= in_cool_factor;
    end
    if (load_setup) begin
      a_r        <= sa0;
      a_end_r    <= sa1;
      b_r        <= sb0;
      da_r       <= s_da;
      db_r       <= s_db;
      err_r      <= EW'(s_da);
      steep_r    <= steep;
      step_neg_r <= s_step_neg;
    end else if (line_adv) begin
      a_r <= a_r + 1'b1;
      if (err_sub[EW-1]) begin
        b_r   <= step_neg_r ? b_r - 1'b1 : b_r + 1'b1;
        err_r <= err_add;
      end else begin
        err_r <= err_sub;
      end
    end
  end

endmodule

/* rtl/hlr_update.sv */
`timescale 1ns / 1ps
// hlr_update: read-modify-write datapath of the heat store and colour blend
// depends on hlr_pkg and hlr_cdiv; six-stage pipeline behind the ram read

module hlr_update
  import hlr_pkg::*;
#(
  parameter int HEAT_BITS = 8,
  parameter int ADDR_W    = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hlr_issue_t           issue,
  input  logic [ADDR_W-1:0]    rd_addr,
  input  logic [HEAT_BITS-1:0] rd_data,
  input  logic [GAIN_W-1:0]    heat_gain,
  input  logic [COLOR_W-1:0]   cold_color,
  input  logic [COLOR_W-1:0]   hot_color,
  output logic                 wr_en,
  output logic [ADDR_W-1:0]    wr_addr,
  output logic [HEAT_BITS-1:0] wr_data,
  output logic                 pipe_busy,
  output logic                 out_strobe,
  output logic [COORD_W-1:0]   out_pixel_x,
  output logic [COORD_W-1:0]   out_pixel_y,
  output logic [CHAN_W-1:0]    out_heat,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic                 out_last
);

  localparam int HEAT_MAX = (1 << HEAT_BITS) - 1;
  localparam int HALF     = HEAT_MAX / 2;
  localparam int NUM_W    = HEAT_BITS + GAIN_W;
  localparam int NCH      = COLOR_W / CHAN_W;
  localparam logic [HEAT_BITS-1:0] HEAT_FULL = '1;

  // stage registers
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  hlr_issue_t        tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r;
  logic [ADDR_W-1:0] addr1_r, addr2_r, addr3_r;
  logic [NUM_W-1:0]  num2_r;
  logic [NUM_W-1:0]  hn4_r, hn5_r;
  logic [NUM_W-1:0]  pc4_r [NCH];
  logic [NUM_W-1:0]  ph4_r [NCH];
  logic [NUM_W-1:0]  bn5_r [NCH];

  logic [GAIN_W-1:0]    mul_a;
  logic [NUM_W-1:0]     add_c, num1, hn3;
  logic [HEAT_BITS-1:0] nh3;
  logic [CHAN_W-1:0]    chan6 [NCH];

  // heating: g*max + (255-g)*h + 127, cooling: f*h + 127, both over 255
  always_comb begin
    mul_a = tag1_r.cool ? tag1_r.factor : (UNIT_SCALE - heat_gain);
    add_c = tag1_r.cool ? NUM_W'(UNIT_HALF)
          : (NUM_W'(heat_gain) << HEAT_BITS) - NUM_W'(heat_gain) + NUM_W'(UNIT_HALF);
    num1  = NUM_W'(mul_a) * NUM_W'(rd_data) + add_c;
  end

  hlr_cdiv #(
    .NUM_W   (NUM_W),
    .DIVISOR (255),
    .Q_W     (HEAT_BITS)
  ) u_div_heat (
    .clk (clk),
    .num (num2_r),
    .quo (nh3)
  );

  // new heat rescaled to 255 = 1.0
  assign hn3 = (NUM_W'(nh3) << GAIN_W) - NUM_W'(nh3) + NUM_W'(HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= issue.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && !tag3_r.cool;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r  <= issue;
    addr1_r <= rd_addr;
    tag2_r  <= tag1_r;
    addr2_r <= addr1_r;
    num2_r  <= num1;
    tag3_r  <= tag2_r;
    addr3_r <= addr2_r;
    tag4_r  <= tag3_r;
    hn4_r   <= hn3;
    tag5_r  <= tag4_r;
    hn5_r   <= hn4_r;
    tag6_r  <= tag5_r;
  end

  for (genvar c = 0; c < NCH; c++) begin : g_chan
    localparam int LSB = CHAN_W * (NCH - 1 - c);

    always_ff @(posedge clk) begin
      pc4_r[c] <= NUM_W'(cold_color[LSB +: CHAN_W]) * NUM_W'(HEAT_FULL - nh3);
      ph4_r[c] <= NUM_W'(hot_color[LSB +: CHAN_W]) * NUM_W'(nh3);
      bn5_r[c] <= pc4_r[c] + ph4_r[c] + NUM_W'(HALF);
    end

    hlr_cdiv #(
      .NUM_W   (NUM_W),
      .DIVISOR (HEAT_MAX),
      .Q_W     (CHAN_W)
    ) u_div_chan (
      .clk (clk),
      .num (bn5_r[c]),
      .quo (chan6[c])
    );
  end

  hlr_cdiv #(
    .NUM_W   (NUM_W),
    .DIVISOR (HEAT_MAX),
    .Q_W     (CHAN_W)
  ) u_div_out (
    .clk (clk),
    .num (hn5_r),
    .quo (out_heat)
  );

  // write back once the new heat is known
  assign wr_en     = v3_r;
  assign wr_addr   = addr3_r;
  assign wr_data   = nh3;
  assign pipe_busy = v1_r || v2_r || v3_r;

  assign out_strobe  = v6_r;
  assign out_pixel_x = tag6_r.x;
  assign out_pixel_y = tag6_r.y;
  assign out_red     = chan6[0];
  assign out_green   = chan6[1];
  assign out_blue    = chan6[2];
  assign out_last    = tag6_r.last;

endmodule

/* rtl/heat_line_rasterizer.sv */
`timescale 1ns / 1ps
// heat_line_rasterizer: top level - config registers, heat store ram, sequencer, datapath
// depends on hlr_pkg, hlr_ram, hlr_seq, hlr_update
//
// after reset the heat store is zeroed by a pass over every entry, busy high
// line: one pixel per cycle from one ram read port; the first result follows the setup
// step and the update pipeline, pixels come out back to back, busy until write-back ends
// cool: sweeps the store at one entry per cycle, no results, busy until write-back ends
// results are strobed for one cycle each; the receiver cannot stall

module heat_line_rasterizer
  import hlr_pkg::*;
#(
  parameter int MAP_SIDE  = 64,
  parameter int HEAT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_operation,
  input  logic [COORD_W-1:0]   in_x_start,
  input  logic [COORD_W-1:0]   in_y_start,
  input  logic [COORD_W-1:0]   in_x_end,
  input  logic [COORD_W-1:0]   in_y_end,
  input  logic [GAIN_W-1:0]    in_cool_factor,
  // results
  output logic                 out_strobe,
  output logic [COORD_W-1:0]   out_pixel_x,
  output logic [COORD_W-1:0]   out_pixel_y,
  output logic [CHAN_W-1:0]    out_heat,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic                 out_last,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);

  // configuration registers
  logic [GAIN_W-1:0]  heat_gain_r;
  logic [COLOR_W-1:0] cold_color_r;
  logic [COLOR_W-1:0] hot_color_r;

  // sequencer to datapath
  hlr_issue_t    issue;
  logic [AW-1:0] rd_addr;
  logic          clr_we;
  logic [AW-1:0] clr_addr;
  logic          pipe_busy;

  // ram ports
  logic                 upd_we;
  logic [AW-1:0]        upd_addr;
  logic [HEAT_BITS-1:0] upd_data;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [HEAT_BITS-1:0] ram_wdata;
  logic [HEAT_BITS-1:0] ram_rdata;

  // register file always takes a transfer; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_gain_r  <= HEAT_GAIN_RST;
      cold_color_r <= COLD_COLOR_RST;
      hot_color_r  <= HOT_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAT_GAIN:  heat_gain_r  <= cfg_data[GAIN_W-1:0];
        CFG_COLD_COLOR: cold_color_r <= cfg_data;
        CFG_HOT_COLOR:  hot_color_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hlr_seq #(
    .MAP_SIDE (MAP_SIDE)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .pipe_busy      (pipe_busy),
    .in_operation   (in_operation),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_cool_factor (in_cool_factor),
    .busy           (busy),
    .issue          (issue),
    .rd_addr        (rd_addr),
    .clr_we         (clr_we),
    .clr_addr       (clr_addr)
  );

  // clearing pass and write-back never overlap: clear owns the port until idle
  assign ram_we    = clr_we || upd_we;
  assign ram_waddr = clr_we ? clr_addr : upd_addr;
  assign ram_wdata = clr_we ? '0 : upd_data;

  hlr_ram #(
    .WIDTH (HEAT_BITS),
    .DEPTH (DEPTH)
  ) u_heat_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue.valid),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // pixels of one line and entries of one sweep are distinct, so reads never
  // meet a pending write; busy holds new commands off until write-back ends
  hlr_update #(
    .HEAT_BITS (HEAT_BITS),
    .ADDR_W    (AW)
  ) u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue       (issue),
    .rd_addr     (rd_addr),
    .rd_data     (ram_rdata),
    .heat_gain   (heat_gain_r),
    .cold_color  (cold_color_r),
    .hot_color   (hot_color_r),
    .wr_en       (upd_we),
    .wr_addr     (upd_addr),
    .wr_data     (upd_data),
    .pipe_busy   (pipe_busy),
    .out_strobe  (out_strobe),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_heat    (out_heat),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_last    (out_last)
  );

endmodule

/* rtl/hlr_checker.sv */
`timescale 1ns / 1ps
// hlr_checker: port-level assertions for heat_line_rasterizer
// bound to the top level; no other dependencies

module hlr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_last
);

  // an accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // pixels of one line come out back to back
  a_line_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("gap inside a line burst");

  // the last pixel closes the burst
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !out_strobe)
    else $error("result right after last pixel");

  // every result stems from work in flight earlier, while busy was high
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy, 3))
    else $error("result without earlier busy");

endmodule

bind heat_line_rasterizer hlr_checker u_hlr_checker (.*);
